// ===== hw/rtl/sfs_pkg.sv =====
// Shared types and constants for the sprite frame sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sfs_pkg;

	// Field and datapath widths
	localparam int unsigned FRAME_W    = 8;
	localparam int unsigned CNT_W      = 9;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned ACC_W      = TIME_W + 1;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned SHEET_W    = 13;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MAX_FRAMES = 256;

	// Shared divider and multiplier operand width
	localparam int unsigned DIV_W      = 13;
	localparam int unsigned DIV_STEP_W = $clog2(DIV_W);
	localparam int unsigned PROD_W     = 2 * DIV_W;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANIM_MODE    = 3'd0,
		REG_FRAME_COUNT  = 3'd1,
		REG_FRAME_PERIOD = 3'd2,
		REG_ORIGIN_X     = 3'd3,
		REG_ORIGIN_Y     = 3'd4,
		REG_TILE_WIDTH   = 3'd5,
		REG_TILE_HEIGHT  = 3'd6,
		REG_SHEET_WIDTH  = 3'd7
	} cfg_reg_t;

	// Command codes
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_PLAY   = 1'b1;

	// Playback modes: bit0 reverse, bit1 ping-pong, bit2 loop
	localparam logic [MODE_W-1:0] MODE_FWD           = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REV           = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PING          = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PING_REV      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LOOP          = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LOOP_PING     = 3'd6;
	localparam logic [MODE_W-1:0] MODE_LOOP_PING_REV = 3'd7;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] elapsed;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic               playing;
		logic [COORD_W-1:0] tile_x;
		logic [COORD_W-1:0] tile_y;
	} out_item_t;

	// Sheet geometry handed to the placement unit
	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] tile_width;
		logic [COORD_W-1:0] tile_height;
		logic [SHEET_W-1:0] sheet_width;
	} geom_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sfs_pkg for the operand width.
`default_nettype none

module sfs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sfs_pkg::DIV_W-1:0] dividend,
	input  logic [sfs_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [sfs_pkg::DIV_W-1:0] quotient,
	output logic [sfs_pkg::DIV_W-1:0] remainder
);
	import sfs_pkg::*;

	logic [DIV_W-1:0]      quo_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      dvs_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_sub;
	logic           fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == DIV_STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sfs_place.sv =====
// Tile placement unit: pixel origin of a frame on the sprite sheet.
// Uses one shared multiplier and one sfs_div instance; depends on sfs_pkg.
`default_nettype none

module sfs_place (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfs_pkg::FRAME_W-1:0] frame,
	input  sfs_pkg::geom_t              geom,
	output logic                        done,
	output logic [sfs_pkg::COORD_W-1:0] tile_x,
	output logic [sfs_pkg::COORD_W-1:0] tile_y
);
	import sfs_pkg::*;

	typedef enum logic [2:0] {
		P_IDLE,
		P_MUL_X,
		P_TEST,
		P_DIV_ROW,
		P_DIV_COLS,
		P_DIV_K,
		P_MUL_COL,
		P_MUL_ROW
	} pstate_t;

	localparam int unsigned XSUM_W = FRAME_W + COORD_W + 2;
	localparam int unsigned YSUM_W = PROD_W + 1;

	pstate_t            state_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic               done_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [DIV_W-1:0]   off_q;

	logic [COORD_W-1:0] w_eff;
	logic [DIV_W-1:0]   mul_a;
	logic [DIV_W-1:0]   mul_b;
	logic [XSUM_W-1:0]  x_sum;
	logic [XSUM_W-1:0]  x_end;
	logic               wraps;
	logic               sw_ge_ox;
	logic [SHEET_W-1:0] span;
	logic [DIV_W-1:0]   k_n;
	logic [DIV_W-1:0]   cols;
	logic [YSUM_W-1:0]  y_sum;

	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIV_W-1:0]   div_rem;

	// Geometry terms
	always_comb begin
		w_eff    = (geom.tile_width == '0) ? COORD_W'(1) : geom.tile_width;
		x_sum    = XSUM_W'(geom.origin_x) + XSUM_W'(prod_q[FRAME_W+COORD_W-1:0]);
		x_end    = x_sum + XSUM_W'(w_eff);
		wraps    = (x_end > XSUM_W'(geom.sheet_width));
		sw_ge_ox = (geom.sheet_width >= SHEET_W'(geom.origin_x));
		span     = sw_ge_ox ? (geom.sheet_width - SHEET_W'(geom.origin_x))
		                    : (SHEET_W'(geom.origin_x) - geom.sheet_width);
		k_n      = neg_q ? (DIV_W'(frame_q) + off_q) : (DIV_W'(frame_q) - off_q);
		cols     = (div_quo == '0) ? DIV_W'(1) : div_quo;
		y_sum    = YSUM_W'(geom.origin_y) + YSUM_W'(prod_q);
	end

	// Multiplier operand selection
	always_comb begin
		case (state_q)
			P_MUL_X: begin
				mul_a = DIV_W'(frame_q);
				mul_b = DIV_W'(w_eff);
			end
			P_MUL_COL: begin
				mul_a = DIV_W'(w_eff);
				mul_b = div_rem;
			end
			P_MUL_ROW: begin
				mul_a = DIV_W'(geom.tile_height);
				mul_b = div_quo + 1'b1;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider requests: row offset, columns per row, then row and column of k
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(span);
		div_divisor  = DIV_W'(w_eff);
		case (state_q)
			P_TEST: begin
				div_start = wraps;
			end
			P_DIV_ROW: begin
				div_start    = div_done;
				div_dividend = DIV_W'(geom.sheet_width);
			end
			P_DIV_COLS: begin
				div_start    = div_done;
				div_dividend = k_n;
				div_divisor  = cols;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	sfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == P_TEST && !wraps) || (state_q == P_MUL_ROW);
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_MUL_X;
					end
				end
				P_MUL_X: begin
					state_q <= P_TEST;
				end
				P_TEST: begin
					if (wraps) begin
						state_q <= P_DIV_ROW;
					end else begin
						state_q <= P_IDLE;
					end
				end
				P_DIV_ROW: begin
					if (div_done) begin
						state_q <= P_DIV_COLS;
					end
				end
				P_DIV_COLS: begin
					if (div_done) begin
						state_q <= P_DIV_K;
					end
				end
				P_DIV_K: begin
					if (div_done) begin
						state_q <= P_MUL_COL;
					end
				end
				P_MUL_COL: begin
					state_q <= P_MUL_ROW;
				end
				P_MUL_ROW: begin
					state_q <= P_IDLE;
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (start && state_q == P_IDLE) begin
			frame_q <= frame;
		end
		if (state_q == P_TEST) begin
			neg_q <= !sw_ge_ox;
			if (!wraps) begin
				x_q <= (x_sum > XSUM_W'(COORD_MAX)) ? COORD_MAX : x_sum[COORD_W-1:0];
				y_q <= geom.origin_y;
			end
		end
		// Keep the row offset while the divider moves on to the column count
		if (state_q == P_DIV_ROW && div_done) begin
			off_q <= div_quo;
		end
		if (state_q == P_MUL_ROW) begin
			x_q <= (prod_q > PROD_W'(COORD_MAX)) ? COORD_MAX : prod_q[COORD_W-1:0];
		end
	end

	// Row product lands in the cycle after P_MUL_ROW
	logic               row_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pend_q <= 1'b0;
		end else begin
			row_pend_q <= (state_q == P_MUL_ROW);
		end
	end

	logic [COORD_W-1:0] y_row_q;
	always_ff @(posedge clk) begin
		if (row_pend_q) begin
			y_row_q <= (y_sum > YSUM_W'(COORD_MAX)) ? COORD_MAX : y_sum[COORD_W-1:0];
		end
	end

	// Hold which path produced the result
	logic wrapped_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrapped_q <= 1'b0;
		end else if (state_q == P_TEST) begin
			wrapped_q <= wraps;
		end
	end

	logic done_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_d_q <= 1'b0;
		end else begin
			done_d_q <= done_q && wrapped_q;
		end
	end

	assign done   = (done_q && !wrapped_q) || done_d_q;
	assign tile_x = x_q;
	assign tile_y = wrapped_q ? y_row_q : y_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_frame_sequencer.sv =====
// Sprite frame sequencer, one command in flight. A tile on the first row is placed without
// division, a tile on a later row takes three divisions. A playing update first steps the
// frame once per frame period consumed, and reduces the frame modulo the count for each
// step landing at or past the frame count. The next input can be taken in the same cycle
// that out_valid rises, later if a result stalls.
// Asynchronous active-low reset: stopped, frame 0, loop mode, registers at defaults.
`default_nettype none

module sprite_frame_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sfs_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output sfs_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_REDUCE,
		S_PLACE_GO,
		S_PLACE_WAIT,
		S_EMIT
	} state_t;

	// Configuration registers
	logic [MODE_W-1:0]  anim_mode_q;
	logic [CNT_W-1:0]   frame_count_q;
	logic [TIME_W-1:0]  frame_period_q;
	logic [COORD_W-1:0] origin_x_q;
	logic [COORD_W-1:0] origin_y_q;
	logic [COORD_W-1:0] tile_width_q;
	logic [COORD_W-1:0] tile_height_q;
	logic [SHEET_W-1:0] sheet_width_q;

	// Playback state
	state_t             state_q;
	logic [ACC_W-1:0]   accum_q;
	logic               first_q;
	logic [FRAME_W-1:0] cur_q;
	logic               back_q;
	logic               playing_q;
	logic [MODE_W-1:0]  run_mode_q;
	logic [CNT_W-1:0]   red_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [CNT_W-1:0]   cnt_eff;
	logic [TIME_W-1:0]  period_eff;
	logic               due;
	logic [CNT_W:0]     next_f;
	logic               hit_top;
	logic               hit_bottom;
	logic               back_n;
	logic               play_n;
	logic [CNT_W-1:0]   step_v;
	logic               step_neg;

	geom_t              geom;
	logic               place_start;
	logic               place_done;
	logic [COORD_W-1:0] place_x;
	logic [COORD_W-1:0] place_y;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Clamp count and period to their usable ranges
	always_comb begin
		if (frame_count_q == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (frame_count_q > CNT_W'(MAX_FRAMES)) begin
			cnt_eff = CNT_W'(MAX_FRAMES);
		end else begin
			cnt_eff = frame_count_q;
		end
		period_eff = (frame_period_q == '0) ? TIME_W'(1) : frame_period_q;
		due        = (accum_q >= ACC_W'(period_eff));
	end

	// End rules for one frame step
	always_comb begin
		next_f     = back_q ? ((CNT_W+1)'(cur_q) - 1'b1) : ((CNT_W+1)'(cur_q) + 1'b1);
		hit_top    = (next_f == (CNT_W+1)'(cnt_eff));
		hit_bottom = back_q && (cur_q == '0);
		back_n     = back_q;
		play_n     = playing_q;
		if (hit_top) begin
			case (run_mode_q)
				MODE_FWD, MODE_PING_REV: play_n = 1'b0;
				MODE_PING, MODE_LOOP_PING, MODE_LOOP_PING_REV: back_n = !back_q;
				default: back_n = back_q;
			endcase
		end else if (hit_bottom) begin
			case (run_mode_q)
				MODE_REV, MODE_PING: play_n = 1'b0;
				MODE_PING_REV, MODE_LOOP_PING, MODE_LOOP_PING_REV: back_n = !back_q;
				default: back_n = back_q;
			endcase
		end
		step_neg = back_n && (cur_q == '0);
		step_v   = back_n ? (CNT_W'(cur_q) - 1'b1) : (CNT_W'(cur_q) + 1'b1);
	end

	always_comb begin
		geom.origin_x    = origin_x_q;
		geom.origin_y    = origin_y_q;
		geom.tile_width  = tile_width_q;
		geom.tile_height = tile_height_q;
		geom.sheet_width = sheet_width_q;
	end

	assign place_start = (state_q == S_PLACE_GO);

	sfs_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (place_start),
		.frame  (cur_q),
		.geom   (geom),
		.done   (place_done),
		.tile_x (place_x),
		.tile_y (place_y)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anim_mode_q    <= MODE_LOOP;
			frame_count_q  <= CNT_W'(1);
			frame_period_q <= TIME_W'(1000);
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			tile_width_q   <= COORD_W'(16);
			tile_height_q  <= COORD_W'(16);
			sheet_width_q  <= SHEET_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ANIM_MODE:    anim_mode_q    <= cfg_data[MODE_W-1:0];
				REG_FRAME_COUNT:  frame_count_q  <= cfg_data[CNT_W-1:0];
				REG_FRAME_PERIOD: frame_period_q <= cfg_data[TIME_W-1:0];
				REG_ORIGIN_X:     origin_x_q     <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data[COORD_W-1:0];
				REG_TILE_WIDTH:   tile_width_q   <= cfg_data[COORD_W-1:0];
				REG_TILE_HEIGHT:  tile_height_q  <= cfg_data[COORD_W-1:0];
				REG_SHEET_WIDTH:  sheet_width_q  <= cfg_data[SHEET_W-1:0];
				default:          anim_mode_q    <= anim_mode_q;
			endcase
		end
	end

	// Sequencer, playback state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			accum_q     <= '0;
			first_q     <= 1'b1;
			cur_q       <= '0;
			back_q      <= 1'b0;
			playing_q   <= 1'b0;
			run_mode_q  <= MODE_LOOP;
			red_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.cmd == CMD_PLAY) begin
							state_q    <= S_PLACE_GO;
							run_mode_q <= anim_mode_q;
							playing_q  <= 1'b1;
							first_q    <= 1'b1;
							accum_q    <= '0;
							back_q     <= anim_mode_q[0];
							cur_q      <= anim_mode_q[0] ? FRAME_W'(cnt_eff - 1'b1) : '0;
						end else if (playing_q && !first_q) begin
							accum_q <= accum_q + ACC_W'(in_data.elapsed);
							state_q <= S_STEP;
						end else begin
							// Clear the accumulator on the first update after a play
							if (playing_q) begin
								accum_q <= '0;
								first_q <= 1'b0;
							end
							state_q <= S_PLACE_GO;
						end
					end
				end
				S_STEP: begin
					// Consume one period per cycle while no reduction is pending; stop ends the loop
					if (!playing_q || !due) begin
						state_q <= S_PLACE_GO;
					end else begin
						accum_q   <= accum_q - ACC_W'(period_eff);
						back_q    <= back_n;
						playing_q <= play_n;
						if (play_n) begin
							if (step_neg) begin
								cur_q <= FRAME_W'(cnt_eff - 1'b1);
							end else if (step_v < cnt_eff) begin
								cur_q <= step_v[FRAME_W-1:0];
							end else begin
								red_q   <= step_v;
								state_q <= S_REDUCE;
							end
						end
					end
				end
				S_REDUCE: begin
					// Take the frame modulo the count after a step that lands at or past it
					if (red_q >= cnt_eff) begin
						red_q <= red_q - cnt_eff;
					end else begin
						cur_q   <= red_q[FRAME_W-1:0];
						state_q <= S_STEP;
					end
				end
				S_PLACE_GO: begin
					state_q <= S_PLACE_WAIT;
				end
				S_PLACE_WAIT: begin
					if (place_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						out_q.frame_index <= cur_q;
						out_q.playing     <= playing_q;
						out_q.tile_x      <= place_x;
						out_q.tile_y      <= place_y;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfs_checker.sv =====
// Port-level checks for the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg for the payload types.
`default_nettype none

module sfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input sfs_pkg::out_item_t out_data
);
	import sfs_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Go busy after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// No result can appear in the cycle right after an input transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// A result rises only while, or just after, an item is in work
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready || $past(!in_ready))
		else $error("result appeared without an item in work");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
